FILE: hw/rtl/psm_pkg.sv
// Shared constants and types for the preemption share monitor.
// Used by psm_alu, psm_cfg and preemption_share_monitor_core; no dependencies.

package psm_pkg;

    localparam int STAMP_W     = 64;
    localparam int PERIOD_W    = 48;
    localparam int EST_W       = 32;
    localparam int BUSY_W      = 14;
    localparam int EVENTS_W    = 32;
    localparam int LOST_W      = 64;
    localparam int ELAPSED_W   = 64;
    localparam int ALU_W       = LOST_W + 2;
    localparam int MUL_W       = 32;
    localparam int SCALE_W     = 14;
    localparam int PROD_W      = MUL_W + SCALE_W;
    localparam int DIV_CNT_W   = $clog2(BUSY_W);
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = PERIOD_W;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_FIELD_W = BUSY_W + EVENTS_W + ELAPSED_W + LOST_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam logic [PERIOD_W-1:0]    RESET_PERIOD   = PERIOD_W'(64'd1000000000);
    localparam logic [EST_W-1:0]       RESET_ESTIMATE = EST_W'(64'd50000);
    localparam logic [SCALE_W-1:0]     HUNDREDTHS     = SCALE_W'(10000);
    localparam logic [BUSY_W-1:0]      BUSY_MAX       = BUSY_W'(10000);

    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ESTIMATE   = 1'b1;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [EST_W-1:0]    init_est;
    } psm_cfg_t;

endpackage

FILE: hw/rtl/preemption_share_monitor_core.sv
// Top level of the preemption share monitor: sequencer, state and output register.
// Depends on psm_pkg, psm_cfg and psm_alu.
//
// Usage: timestamps enter on the s_ channel, one transfer per stamp. Reports leave on
// the m_ channel, one transfer per finished period. The user must write registers
// on the cfg_ channel only while the block is idle; the block does not enforce it.
// cfg_ready is always high. The first stamp after reset primes the block and gives
// no report. A stamp that ends a period runs its sequencer steps on the shared 66-bit
// adder and a 32x14 multiplier, then a restoring divide that produces one quotient
// bit per cycle for the 14-bit result; if the lost cycles reach the elapsed cycles,
// the multiply and divide are skipped and the busy share is zero.
// s_tready is high only while the sequencer waits for a stamp.
// The report sits in an output register, so the next stamp is taken while the report
// waits; if a second report is ready before the first was taken, the sequencer holds
// until m_tready frees the output register.
// Reset clears the sequencer, the primed flag, the accumulators and m_tvalid, and
// loads the register defaults (period 1000000000, estimate 50000).

module preemption_share_monitor_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [63:0] timestamp
    input  logic [psm_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [13:0] busy_hundredths, [45:14] preempt_events, [109:46] elapsed_cycles,
    // [173:110] preempted_cycles, [175:174] zero
    output logic [psm_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [psm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [psm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import psm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PRIME,
        S_GAP,
        S_THR,
        S_LOST_ADD,
        S_LOST_SUB,
        S_EST_DECAY,
        S_EST_ADD,
        S_RPT,
        S_ELAP,
        S_NUM,
        S_MUL_LO,
        S_HALF,
        S_MUL_HI,
        S_DIV,
        S_ADV,
        S_EMIT
    } state_t;

    psm_cfg_t cfg;

    state_t                 state_reg;
    logic                   primed_reg;
    logic [STAMP_W-1:0]     ts_reg;
    logic [STAMP_W-1:0]     prev_reg;
    logic [STAMP_W-1:0]     start_reg;
    logic [STAMP_W-1:0]     next_reg;
    logic [STAMP_W-1:0]     gap_reg;
    logic [STAMP_W-1:0]     elapsed_reg;
    logic [EST_W-1:0]       est_reg;
    logic [LOST_W-1:0]      lost_reg;
    logic [EVENTS_W-1:0]    events_reg;
    logic [LOST_W-1:0]      num_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [LOST_W-1:0]      acc_reg;
    logic [LOST_W-1:0]      rem_reg;
    logic [BUSY_W-1:0]      dl_reg;
    logic [BUSY_W-1:0]      quot_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;

    logic                   m_tvalid_reg;
    logic [BUSY_W-1:0]      out_busy_reg;
    logic [EVENTS_W-1:0]    out_events_reg;
    logic [ELAPSED_W-1:0]   out_elapsed_reg;
    logic [LOST_W-1:0]      out_lost_reg;

    logic [ALU_W-1:0]       alu_a;
    logic [ALU_W-1:0]       alu_b;
    alu_op_t                alu_op;
    logic [ALU_W-1:0]       alu_y;
    logic                   alu_borrow;
    logic [MUL_W-1:0]       mul_a;
    logic [PROD_W-1:0]      mul_y;
    logic [LOST_W:0]        div_rem;
    logic [BUSY_W+LOST_W-1:0] dividend;
    logic                   out_free;
    logic                   take_in;

    psm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    psm_alu u_alu (
        .a  (alu_a),
        .b  (alu_b),
        .op (alu_op),
        .y  (alu_y)
    );

    assign alu_borrow = alu_y[ALU_W-1];
    assign div_rem    = {rem_reg, dl_reg[BUSY_W-1]};
    assign dividend   = {alu_y[PROD_W-1:0], acc_reg[MUL_W-1:0]};
    assign mul_a      = (state_reg == S_MUL_LO) ? num_reg[MUL_W-1:0]
                                                : num_reg[LOST_W-1:MUL_W];
    assign mul_y      = PROD_W'(mul_a) * PROD_W'(HUNDREDTHS);

    assign s_tready   = (state_reg == S_IDLE);
    assign take_in    = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {{OUT_PAD_W{1'b0}}, out_lost_reg, out_elapsed_reg,
                         out_events_reg, out_busy_reg};

    always_comb
    begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = ALU_ADD;
        case (state_reg)
            S_PRIME:
            begin
                alu_a = ALU_W'(ts_reg);
                alu_b = ALU_W'(cfg.period);
            end
            S_GAP:
            begin
                alu_a  = ALU_W'(ts_reg);
                alu_b  = ALU_W'(prev_reg);
                alu_op = ALU_SUB;
            end
            S_THR:
            begin
                alu_a  = ALU_W'({est_reg, 1'b0});
                alu_b  = ALU_W'(gap_reg);
                alu_op = ALU_SUB;
            end
            S_LOST_ADD:
            begin
                alu_a = ALU_W'(lost_reg);
                alu_b = ALU_W'(gap_reg);
            end
            S_LOST_SUB:
            begin
                alu_a  = ALU_W'(lost_reg);
                alu_b  = ALU_W'(est_reg);
                alu_op = ALU_SUB;
            end
            S_EST_DECAY:
            begin
                alu_a = ALU_W'(est_reg >> 1);
                alu_b = ALU_W'(est_reg >> 2);
            end
            S_EST_ADD:
            begin
                alu_a = ALU_W'(est_reg);
                alu_b = ALU_W'(gap_reg >> 2);
            end
            S_RPT:
            begin
                alu_a  = ALU_W'(next_reg);
                alu_b  = ALU_W'(ts_reg);
                alu_op = ALU_SUB;
            end
            S_ELAP:
            begin
                alu_a  = ALU_W'(ts_reg);
                alu_b  = ALU_W'(start_reg);
                alu_op = ALU_SUB;
            end
            S_NUM:
            begin
                alu_a  = ALU_W'(elapsed_reg);
                alu_b  = ALU_W'(lost_reg);
                alu_op = ALU_SUB;
            end
            S_HALF:
            begin
                alu_a = ALU_W'(elapsed_reg >> 1);
                alu_b = ALU_W'(prod_reg);
            end
            S_MUL_HI:
            begin
                alu_a = ALU_W'(acc_reg[LOST_W-1:MUL_W]);
                alu_b = ALU_W'(prod_reg);
            end
            S_DIV:
            begin
                alu_a  = ALU_W'(div_rem);
                alu_b  = ALU_W'(elapsed_reg);
                alu_op = ALU_SUB;
            end
            S_ADV:
            begin
                alu_a = ALU_W'(next_reg);
                alu_b = ALU_W'(cfg.period);
            end
            default:
            begin
                alu_a  = '0;
                alu_b  = '0;
                alu_op = ALU_ADD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            primed_reg   <= 1'b0;
            lost_reg     <= '0;
            events_reg   <= '0;
            est_reg      <= RESET_ESTIMATE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_EMIT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (take_in)
                    begin
                        ts_reg    <= s_tdata[STAMP_W-1:0];
                        state_reg <= primed_reg ? S_GAP : S_PRIME;
                    end
                end
                S_PRIME:
                begin
                    primed_reg <= 1'b1;
                    prev_reg   <= ts_reg;
                    start_reg  <= ts_reg;
                    est_reg    <= cfg.init_est;
                    next_reg   <= alu_y[STAMP_W-1:0];
                    state_reg  <= S_IDLE;
                end
                S_GAP:
                begin
                    gap_reg   <= alu_y[STAMP_W-1:0];
                    prev_reg  <= ts_reg;
                    state_reg <= S_THR;
                end
                S_THR:
                begin
                    if (alu_borrow)
                    begin
                        if (events_reg != '1)
                        begin
                            events_reg <= events_reg + EVENTS_W'(1);
                        end
                        state_reg <= S_LOST_ADD;
                    end
                    else
                    begin
                        state_reg <= S_EST_DECAY;
                    end
                end
                S_LOST_ADD:
                begin
                    lost_reg  <= alu_y[LOST_W-1:0];
                    state_reg <= S_LOST_SUB;
                end
                S_LOST_SUB:
                begin
                    lost_reg  <= alu_y[LOST_W-1:0];
                    state_reg <= S_RPT;
                end
                S_EST_DECAY:
                begin
                    est_reg   <= alu_y[EST_W-1:0];
                    state_reg <= S_EST_ADD;
                end
                S_EST_ADD:
                begin
                    est_reg   <= alu_y[EST_W-1:0];
                    state_reg <= S_RPT;
                end
                S_RPT:
                begin
                    state_reg <= alu_borrow ? S_ELAP : S_IDLE;
                end
                S_ELAP:
                begin
                    elapsed_reg <= alu_y[STAMP_W-1:0];
                    state_reg   <= S_NUM;
                end
                S_NUM:
                begin
                    num_reg <= alu_y[LOST_W-1:0];
                    if (alu_borrow || (alu_y[LOST_W-1:0] == '0))
                    begin
                        quot_reg  <= '0;
                        state_reg <= S_ADV;
                    end
                    else
                    begin
                        state_reg <= S_MUL_LO;
                    end
                end
                S_MUL_LO:
                begin
                    prod_reg  <= mul_y;
                    state_reg <= S_HALF;
                end
                S_HALF:
                begin
                    acc_reg   <= alu_y[LOST_W-1:0];
                    prod_reg  <= mul_y;
                    state_reg <= S_MUL_HI;
                end
                S_MUL_HI:
                begin
                    rem_reg   <= dividend[BUSY_W+LOST_W-1:BUSY_W];
                    dl_reg    <= dividend[BUSY_W-1:0];
                    quot_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= alu_borrow ? div_rem[LOST_W-1:0] : alu_y[LOST_W-1:0];
                    quot_reg <= {quot_reg[BUSY_W-2:0], !alu_borrow};
                    dl_reg   <= {dl_reg[BUSY_W-2:0], 1'b0};
                    cnt_reg  <= cnt_reg + DIV_CNT_W'(1);
                    if (cnt_reg == DIV_CNT_W'(BUSY_W - 1))
                    begin
                        state_reg <= S_ADV;
                    end
                end
                S_ADV:
                begin
                    next_reg  <= alu_y[STAMP_W-1:0];
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_busy_reg    <= quot_reg;
                        out_events_reg  <= events_reg;
                        out_elapsed_reg <= ELAPSED_W'(elapsed_reg);
                        out_lost_reg    <= lost_reg;
                        start_reg       <= ts_reg;
                        lost_reg        <= '0;
                        events_reg      <= '0;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_busy_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[BUSY_W-1:0] <= BUSY_MAX))
        else $error("busy share above full scale");

    a_busy_needs_margin: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_busy_reg != '0)) |-> (out_lost_reg < out_elapsed_reg))
        else $error("nonzero busy share with lost cycles not below elapsed cycles");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg <= DIV_CNT_W'(BUSY_W - 1)))
        else $error("divide step counter out of range");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        take_in |=> !s_tready)
        else $error("stamp accepted while the previous one is still at work");

    a_period_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> (lost_reg == '0 && events_reg == '0))
        else $error("accumulators not cleared after a report");

endmodule

FILE: hw/rtl/psm_alu.sv
// Shared add/subtract unit of the preemption share monitor sequencer.
// Depends on psm_pkg for the operand width and the operation type.

module psm_alu (
    input  logic [psm_pkg::ALU_W-1:0] a,
    input  logic [psm_pkg::ALU_W-1:0] b,
    input  psm_pkg::alu_op_t          op,
    output logic [psm_pkg::ALU_W-1:0] y
);
    import psm_pkg::*;

    always_comb
    begin
        case (op)
            ALU_ADD: y = a + b;
            ALU_SUB: y = a - b;
            default: y = a + b;
        endcase
    end

endmodule

FILE: hw/rtl/psm_cfg.sv
// Configuration registers of the preemption share monitor.
// Depends on psm_pkg for register indexes, widths and reset values.

module psm_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [psm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [psm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output psm_pkg::psm_cfg_t               regs
);
    import psm_pkg::*;

    psm_cfg_t regs_reg;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.period   <= RESET_PERIOD;
            regs_reg.init_est <= RESET_ESTIMATE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PERIOD:   regs_reg.period   <= cfg_data[PERIOD_W-1:0];
                CFG_ESTIMATE: regs_reg.init_est <= cfg_data[EST_W-1:0];
                default:      regs_reg          <= regs_reg;
            endcase
        end
    end

endmodule
